/* sv/tcft_pkg.sv */
// Shared widths, register indexes and helpers for the touch contact filter tracker.
// No dependencies; imported by touch_contact_filter_tracker_top.
`default_nettype none

package tcft_pkg;

    localparam int POS_W   = 13;
    localparam int ID_W    = 8;
    localparam int CNT_W   = 3;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int WIDE_W  = POS_W + 2;

    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [WIDE_W-1:0] wpos_t;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_IGNORE_NEAR   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_PALM_REJECT   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_IGNORE_BUTTON = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BUTTON_DIS    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_STOP_PRESSURE = 3'd4;
    localparam logic [CIDX_W-1:0] REG_STOP_SIZE     = 3'd5;
    localparam logic [CIDX_W-1:0] REG_X_MIN         = 3'd6;
    localparam logic [CIDX_W-1:0] REG_Y_MIN         = 3'd7;

    // Item kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_FINGER = 1'b1;

    // Finger state bits and type codes
    localparam int          FSTATE_VALID_BIT = 2;
    localparam int          FSTATE_FLOAT_BIT = 1;
    localparam logic [3:0]  FTYPE_PALM       = 4'd6;

    localparam logic [CFG_W-1:0] STOP_OFF = 32'hFFFF_FFFF;
    localparam pos_t             POS_MAX  = 13'h1FFF;

    // Clamp an offset position into 0..POS_MAX
    function automatic pos_t clamp_pos(input wpos_t v);
        pos_t r;
        if (v <= 0) begin
            r = '0;
        end else if (v > $signed({2'b00, POS_MAX})) begin
            r = POS_MAX;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/touch_contact_filter_tracker_top.sv */
// A transfer is held in the input register and its result in the m_ result register.
// Throughput: one item per cycle while m_ready keeps up; the input register feeds one
// compute stage that updates the two tracking slots and loads the result register.
// Surplus fingers (no contacts left in the report) are consumed with no result.
// Reset (aresetn low, synchronous): both slots free, button history and finger
// count cleared, configuration registers at their documented reset values.
`default_nettype none

module touch_contact_filter_tracker_top #(
    parameter int MAX_CONTACTS = 5
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    // configuration write port
    input  wire                          cfg_wr_en,
    input  wire [tcft_pkg::CIDX_W-1:0]   cfg_index,
    input  wire [tcft_pkg::CFG_W-1:0]    cfg_wdata,

    // input channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_kind,
    input  wire                          s_button,
    input  wire [15:0]                   s_timestamp,
    input  wire [7:0]                    s_finger_count,
    input  wire [tcft_pkg::ID_W-1:0]     s_finger_id,
    input  wire [tcft_pkg::POS_W-1:0]    s_raw_x,
    input  wire [tcft_pkg::POS_W-1:0]    s_raw_y,
    input  wire [3:0]                    s_finger_state,
    input  wire [3:0]                    s_finger_type,
    input  wire [7:0]                    s_pressure,
    input  wire [7:0]                    s_contact_size,

    // result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_result_kind,
    output logic                         m_button_clicked,
    output logic [15:0]                  m_scan_time,
    output logic [tcft_pkg::CNT_W-1:0]   m_contact_count,
    output logic [tcft_pkg::ID_W-1:0]    m_contact_id,
    output logic [tcft_pkg::POS_W-1:0]   m_pos_x,
    output logic [tcft_pkg::POS_W-1:0]   m_pos_y,
    output logic                         m_tip_switch,
    output logic                         m_confidence
);
    import tcft_pkg::*;

    localparam logic [7:0]       MAX_CNT8 = 8'(MAX_CONTACTS);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_CONTACTS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              ignore_near_reg;
    logic              palm_reject_reg;
    logic              ignore_button_reg;
    logic              button_dis_reg;
    logic [CFG_W-1:0]  stop_pressure_reg;
    logic [CFG_W-1:0]  stop_size_reg;
    logic [POS_W-1:0]  x_min_reg;
    logic [POS_W-1:0]  y_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_near_reg   <= 1'b1;
            palm_reject_reg   <= 1'b0;
            ignore_button_reg <= 1'b1;
            button_dis_reg    <= 1'b0;
            stop_pressure_reg <= '0;
            stop_size_reg     <= STOP_OFF;
            x_min_reg         <= '0;
            y_min_reg         <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IGNORE_NEAR:   ignore_near_reg   <= cfg_wdata[0];
                REG_PALM_REJECT:   palm_reject_reg   <= cfg_wdata[0];
                REG_IGNORE_BUTTON: ignore_button_reg <= cfg_wdata[0];
                REG_BUTTON_DIS:    button_dis_reg    <= cfg_wdata[0];
                REG_STOP_PRESSURE: stop_pressure_reg <= cfg_wdata;
                REG_STOP_SIZE:     stop_size_reg     <= cfg_wdata;
                REG_X_MIN:         x_min_reg         <= cfg_wdata[POS_W-1:0];
                REG_Y_MIN:         y_min_reg         <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the input register advances whenever the result register
    // can take what the compute stage produces (or is being drained).
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic s1_fire;
    logic s_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    // Input register: payload needs no reset
    logic              s1_kind_reg;
    logic              s1_button_reg;
    logic [15:0]       s1_timestamp_reg;
    logic [7:0]        s1_count_reg;
    logic [ID_W-1:0]   s1_id_reg;
    logic [POS_W-1:0]  s1_raw_x_reg;
    logic [POS_W-1:0]  s1_raw_y_reg;
    logic [3:0]        s1_state_reg;
    logic [3:0]        s1_type_reg;
    logic [7:0]        s1_pressure_reg;
    logic [7:0]        s1_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_kind_reg      <= s_kind;
            s1_button_reg    <= s_button;
            s1_timestamp_reg <= s_timestamp;
            s1_count_reg     <= s_finger_count;
            s1_id_reg        <= s_finger_id;
            s1_raw_x_reg     <= s_raw_x;
            s1_raw_y_reg     <= s_raw_y;
            s1_state_reg     <= s_finger_state;
            s1_type_reg      <= s_finger_type;
            s1_pressure_reg  <= s_pressure;
            s1_size_reg      <= s_contact_size;
        end
    end

    // ------------------------------------------------------------------
    // Tracking state
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  slot_x_reg     [2];
    logic [POS_W-1:0]  slot_y_reg     [2];
    logic [ID_W-1:0]   slot_id_reg    [2];
    logic [1:0]        slot_free_reg;
    logic [1:0]        slot_touch_reg;
    logic              prev_button_reg;
    logic              cur_button_reg;
    logic [CNT_W-1:0]  fingers_left_reg;

    logic [POS_W-1:0]  slot_x_next    [2];
    logic [POS_W-1:0]  slot_y_next    [2];
    logic [ID_W-1:0]   slot_id_next   [2];
    logic [1:0]        slot_free_next;
    logic [1:0]        slot_touch_next;
    logic              prev_button_next;
    logic              cur_button_next;
    logic [CNT_W-1:0]  fingers_left_next;

    // Compute stage results
    logic              produce;
    logic              btn;
    logic [15:0]       scan_time;
    logic [CNT_W-1:0]  count_sat;
    wpos_t             rx_ext;
    wpos_t             ry_neg;
    wpos_t             x_off;
    wpos_t             y_off;
    pos_t              px;
    pos_t              py;
    logic              tip;
    logic              conf;
    logic              ok_btn;
    logic              ok_press;
    logic              ok_size;
    logic              do_update;
    logic [1:0]        match;
    logic              sel;
    logic [POS_W-1:0]  out_x;
    logic [POS_W-1:0]  out_y;

    // Header path
    assign btn       = s1_button_reg && !button_dis_reg;
    assign scan_time = {s1_timestamp_reg[12:0], 3'b000} + {s1_timestamp_reg[14:0], 1'b0};
    assign count_sat = (s1_count_reg > MAX_CNT8) ? MAX_CNT : s1_count_reg[CNT_W-1:0];

    // Position: sign extend, negate Y, offset by the minimum and clamp
    assign rx_ext = $signed({{2{s1_raw_x_reg[POS_W-1]}}, s1_raw_x_reg});
    assign ry_neg = -$signed({{2{s1_raw_y_reg[POS_W-1]}}, s1_raw_y_reg});
    assign x_off  = rx_ext - $signed({{2{x_min_reg[POS_W-1]}}, x_min_reg});
    assign y_off  = ry_neg - $signed({{2{y_min_reg[POS_W-1]}}, y_min_reg});
    assign px     = clamp_pos(x_off);
    assign py     = clamp_pos(y_off);

    // Contact flags
    assign tip  = s1_state_reg[FSTATE_VALID_BIT]
                  && (!ignore_near_reg || !s1_state_reg[FSTATE_FLOAT_BIT]);
    assign conf = !palm_reject_reg || (s1_type_reg != FTYPE_PALM);

    // Update rules: button held across two reports, pressure and size gates
    assign ok_btn    = !ignore_button_reg || !prev_button_reg || !cur_button_reg;
    assign ok_press  = (stop_pressure_reg == STOP_OFF)
                       || ({24'd0, s1_pressure_reg} > stop_pressure_reg);
    assign ok_size   = (stop_size_reg == STOP_OFF)
                       || ({24'd0, s1_size_reg} > stop_size_reg);
    assign do_update = ok_btn && ok_press && ok_size;

    assign match[0] = !slot_free_reg[0] && (slot_id_reg[0] == s1_id_reg);
    assign match[1] = !slot_free_reg[1] && (slot_id_reg[1] == s1_id_reg);

    // Slot choice: matching slot first, else slot 0 unless it is touching
    assign sel = match[0] ? 1'b0 : (match[1] ? 1'b1 : slot_touch_reg[0]);

    assign produce = (s1_kind_reg == KIND_HEADER) || (fingers_left_reg != '0);

    always_comb begin
        slot_x_next       = slot_x_reg;
        slot_y_next       = slot_y_reg;
        slot_id_next      = slot_id_reg;
        slot_free_next    = slot_free_reg;
        slot_touch_next   = slot_touch_reg;
        prev_button_next  = prev_button_reg;
        cur_button_next   = cur_button_reg;
        fingers_left_next = fingers_left_reg;
        out_x             = px;
        out_y             = py;

        if (s1_kind_reg == KIND_HEADER) begin
            prev_button_next  = cur_button_reg;
            cur_button_next   = btn;
            fingers_left_next = count_sat;
        end else if (fingers_left_reg != '0) begin
            fingers_left_next = fingers_left_reg - 1'b1;
            if (do_update) begin
                slot_x_next[sel]     = px;
                slot_y_next[sel]     = py;
                slot_id_next[sel]    = s1_id_reg;
                slot_free_next[sel]  = 1'b0;
                slot_touch_next[sel] = tip;
            end else begin
                // Free a lifted contact's slot, or report its held position
                for (int s = 0; s < 2; s++) begin
                    if (match[s]) begin
                        slot_touch_next[s] = tip;
                        if (!tip) begin
                            slot_free_next[s] = 1'b1;
                        end
                    end
                end
                if (match[1] && tip) begin
                    out_x = slot_x_reg[1];
                    out_y = slot_y_reg[1];
                end else if (match[0] && tip) begin
                    out_x = slot_x_reg[0];
                    out_y = slot_y_reg[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 2; s++) begin
                slot_x_reg[s]  <= '0;
                slot_y_reg[s]  <= '0;
                slot_id_reg[s] <= '0;
            end
            slot_free_reg    <= 2'b11;
            slot_touch_reg   <= 2'b00;
            prev_button_reg  <= 1'b0;
            cur_button_reg   <= 1'b0;
            fingers_left_reg <= '0;
        end else if (s1_fire) begin
            slot_x_reg       <= slot_x_next;
            slot_y_reg       <= slot_y_next;
            slot_id_reg      <= slot_id_next;
            slot_free_reg    <= slot_free_next;
            slot_touch_reg   <= slot_touch_next;
            prev_button_reg  <= prev_button_next;
            cur_button_reg   <= cur_button_next;
            fingers_left_reg <= fingers_left_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              m_kind_reg;
    logic              m_button_reg;
    logic [15:0]       m_scan_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic [POS_W-1:0]  m_x_reg;
    logic [POS_W-1:0]  m_y_reg;
    logic              m_tip_reg;
    logic              m_conf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= produce;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            if (s1_kind_reg == KIND_HEADER) begin
                m_kind_reg   <= KIND_HEADER;
                m_button_reg <= btn;
                m_scan_reg   <= scan_time;
                m_count_reg  <= count_sat;
                m_id_reg     <= '0;
                m_x_reg      <= '0;
                m_y_reg      <= '0;
                m_tip_reg    <= 1'b0;
                m_conf_reg   <= 1'b0;
            end else begin
                m_kind_reg   <= KIND_FINGER;
                m_button_reg <= 1'b0;
                m_scan_reg   <= '0;
                m_count_reg  <= '0;
                m_id_reg     <= s1_id_reg;
                m_x_reg      <= out_x;
                m_y_reg      <= out_y;
                m_tip_reg    <= tip;
                m_conf_reg   <= conf;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = m_kind_reg;
    assign m_button_clicked = m_button_reg;
    assign m_scan_time      = m_scan_reg;
    assign m_contact_count  = m_count_reg;
    assign m_contact_id     = m_id_reg;
    assign m_pos_x          = m_x_reg;
    assign m_pos_y          = m_y_reg;
    assign m_tip_switch     = m_tip_reg;
    assign m_confidence     = m_conf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // Remaining finger count never exceeds the contact limit
    a_fingers_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fingers_left_reg <= MAX_CNT)
        else $error("fingers_left exceeds MAX_CONTACTS");

    // Two occupied slots never track the same finger id
    a_slot_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        !(!slot_free_reg[0] && !slot_free_reg[1] && (slot_id_reg[0] == slot_id_reg[1])))
        else $error("both slots hold the same id");

    // A header leaving the compute stage always yields a header result
    a_header_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && (s1_kind_reg == KIND_HEADER)) |=> (m_valid_reg && (m_kind_reg == KIND_HEADER)))
        else $error("header transfer lost its result");

    // Input stalls only while a result waits on the output side
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire
